@@ rtl/core/ssm_pkg.sv @@
// Shared constants and types for the stream substring matcher.
// No dependencies; imported by ssm_window_cmp and stream_substring_matcher_core.
`default_nettype none

package ssm_pkg;

  localparam int unsigned MAX_NEEDLE_DEF  = 32;
  localparam int unsigned PROBE_BYTES_DEF = 4096;

  localparam int unsigned NEEDLE_BYTES = 32;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned WORD_W       = 64;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_WORD_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ONLY     = 3'd5;

  typedef logic [NEEDLE_BYTES-1:0][BYTE_W-1:0] needle_t;

endpackage

`default_nettype wire

@@ rtl/core/ssm_window_cmp.sv @@
// Parallel compare of the byte window against the configured needle.
// Depends on ssm_pkg.
`default_nettype none

module ssm_window_cmp #(
  parameter int unsigned MAX_NEEDLE = ssm_pkg::MAX_NEEDLE_DEF
) (
  input  wire logic [MAX_NEEDLE-1:0][ssm_pkg::BYTE_W-1:0] window,
  input  wire ssm_pkg::needle_t                           needle,
  input  wire logic [ssm_pkg::LEN_W-1:0]                  len,
  output logic                                            hit
);
  import ssm_pkg::*;

  logic [MAX_NEEDLE-1:0] pos_ok;

  // Window entry j holds the byte j steps back; it must equal needle byte len-1-j.
  always_comb begin
    logic [LEN_W-1:0] nidx;
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      nidx = LEN_W'(len - LEN_W'(j) - LEN_W'(1));
      if (LEN_W'(j) < len) begin
        pos_ok[j] = (window[j] == needle[nidx[LEN_W-2:0]]);
      end else begin
        pos_ok[j] = 1'b1;
      end
    end
  end

  assign hit = &pos_ok;

endmodule

`default_nettype wire

@@ rtl/core/stream_substring_matcher_core.sv @@
// Top level of the stream substring matcher: configuration, window, flags, result register.
// Depends on ssm_pkg and ssm_window_cmp.
//
// Usage: the input channel carries one byte per beat, with in_last_byte set on the
// final byte of a stream. Each beat shifts the byte into a window of the most recent
// MAX_NEEDLE bytes, and a parallel compare against the needle sets a sticky match
// flag in the same cycle. Zero bytes among the first PROBE_BYTES bytes are recorded.
// The beat that carries in_last_byte produces one result beat on the output channel,
// valid in the cycle after acceptance, and clears the stream state.
// Throughput is one byte per cycle, set by the combinational window compare.
// The output is a single register; while a result waits and out_ready is low,
// in_ready is low and the stream stalls. Otherwise bytes are accepted back to back.
// Configuration writes on cfg_we take effect at the next clock edge and should be
// made only while no stream is in progress.
// Reset (synchronous, active low) clears the stream state and sets the registers to
// an empty needle with text-only mode enabled.
`default_nettype none

module stream_substring_matcher_core #(
  parameter int unsigned MAX_NEEDLE  = ssm_pkg::MAX_NEEDLE_DEF,
  parameter int unsigned PROBE_BYTES = ssm_pkg::PROBE_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ssm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ssm_pkg::WORD_W-1:0]    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ssm_pkg::BYTE_W-1:0]    in_byte_value,
  input  wire logic                          in_last_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_found,
  output logic                               out_binary_rejected
);
  import ssm_pkg::*;

  localparam int unsigned SEEN_CAP = (PROBE_BYTES > MAX_NEEDLE) ? PROBE_BYTES : MAX_NEEDLE;
  localparam int unsigned SEEN_W   = $clog2(SEEN_CAP + 1);
  localparam int unsigned CMP_W    = (SEEN_W > LEN_W) ? SEEN_W : LEN_W;

  logic [LEN_W-1:0]  needle_length_r;
  logic [WORD_W-1:0] needle_word_0_r;
  logic [WORD_W-1:0] needle_word_1_r;
  logic [WORD_W-1:0] needle_word_2_r;
  logic [WORD_W-1:0] needle_word_3_r;
  logic              text_only_r;

  logic [MAX_NEEDLE-1:0][BYTE_W-1:0] window_r;
  logic [MAX_NEEDLE-1:0][BYTE_W-1:0] window_nxt;
  logic [SEEN_W-1:0]                 bytes_seen_r;
  logic [SEEN_W-1:0]                 bytes_seen_nxt;
  logic                              match_seen_r;
  logic                              match_seen_nxt;
  logic                              zero_in_probe_r;
  logic                              zero_in_probe_nxt;

  logic out_valid_r;
  logic out_found_r;
  logic out_binary_rejected_r;

  logic             in_fire;
  logic [LEN_W-1:0] eff_len;
  logic             window_hit;
  logic             len_reached;
  logic             rejected;
  needle_t          needle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_length_r <= '0;
      needle_word_0_r <= '0;
      needle_word_1_r <= '0;
      needle_word_2_r <= '0;
      needle_word_3_r <= '0;
      text_only_r     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEEDLE_LENGTH: needle_length_r <= cfg_wdata[LEN_W-1:0];
        CFG_NEEDLE_WORD_0: needle_word_0_r <= cfg_wdata;
        CFG_NEEDLE_WORD_1: needle_word_1_r <= cfg_wdata;
        CFG_NEEDLE_WORD_2: needle_word_2_r <= cfg_wdata;
        CFG_NEEDLE_WORD_3: needle_word_3_r <= cfg_wdata;
        CFG_TEXT_ONLY:     text_only_r     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign needle = {needle_word_3_r, needle_word_2_r, needle_word_1_r, needle_word_0_r};

  assign eff_len = (needle_length_r > LEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE) : needle_length_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    window_nxt[0] = in_byte_value;
    for (int k = 1; k < MAX_NEEDLE; k++) begin
      window_nxt[k] = window_r[k-1];
    end
  end

  assign bytes_seen_nxt = (bytes_seen_r < SEEN_W'(SEEN_CAP)) ?
                          SEEN_W'(bytes_seen_r + SEEN_W'(1)) : bytes_seen_r;

  ssm_window_cmp #(
    .MAX_NEEDLE (MAX_NEEDLE)
  ) u_cmp (
    .window (window_nxt),
    .needle (needle),
    .len    (eff_len),
    .hit    (window_hit)
  );

  assign len_reached = CMP_W'(bytes_seen_nxt) >= CMP_W'(eff_len);

  assign match_seen_nxt = match_seen_r || (eff_len == '0) || (len_reached && window_hit);
  assign zero_in_probe_nxt = zero_in_probe_r ||
                             ((in_byte_value == '0) && (bytes_seen_r < SEEN_W'(PROBE_BYTES)));
  assign rejected = text_only_r && zero_in_probe_nxt;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      window_r <= window_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r    <= '0;
      match_seen_r    <= 1'b0;
      zero_in_probe_r <= 1'b0;
    end else if (in_fire) begin
      if (in_last_byte) begin
        bytes_seen_r    <= '0;
        match_seen_r    <= 1'b0;
        zero_in_probe_r <= 1'b0;
      end else begin
        bytes_seen_r    <= bytes_seen_nxt;
        match_seen_r    <= match_seen_nxt;
        zero_in_probe_r <= zero_in_probe_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last_byte) begin
      out_found_r           <= match_seen_nxt && !rejected;
      out_binary_rejected_r <= rejected;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_found           = out_found_r;
  assign out_binary_rejected = out_binary_rejected_r;

endmodule

`default_nettype wire
